// ----- rtl/stpm_pkg.sv -----
// ----------------------------------------------------------------------------
// stpm_pkg: shared types and constants for the sparse challenge multiplier
// Field widths, command codes and the structs between sequencer and ALU.
// ----------------------------------------------------------------------------
package stpm_pkg;

  localparam int CMD_W   = 2;
  localparam int POLY_W  = 3;
  localparam int COEFF_W = 8;
  localparam int VALUE_W = 21;
  localparam int BOUND_W = 21;
  localparam int SEC_W   = 4;
  localparam int ACC_W   = 12;
  localparam int SUM_W   = 22;

  localparam logic [BOUND_W-1:0] BOUND_RESET = 21'd524092;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CHAL  = 2'd1,
    CMD_MASK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Operands for the shared adder plus the registered sum for the norm check
  typedef struct packed {
    logic signed [SUM_W-1:0] op_a;
    logic signed [SUM_W-1:0] op_b;
    logic signed [SUM_W-1:0] z;
  } alu_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic signed [VALUE_W-1:0] z_sat;
    logic                      oob;
  } alu_rsp_t;

endpackage

// ----- rtl/stpm_ram.sv -----
// ----------------------------------------------------------------------------
// stpm_ram: single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on contents.
// ----------------------------------------------------------------------------
module stpm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1280
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/stpm_alu.sv -----
// ----------------------------------------------------------------------------
// stpm_alu: shared adder with accumulator saturation, and the norm check
// The adder serves both accumulator updates and the y + acc sum.
// ----------------------------------------------------------------------------
module stpm_alu (
  input  stpm_pkg::alu_req_t                 req_i,
  input  logic [stpm_pkg::BOUND_W-1:0]       bound_i,
  output stpm_pkg::alu_rsp_t                 rsp_o
);
  import stpm_pkg::*;

  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(2047);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -SUM_W'(2048);
  localparam logic signed [SUM_W-1:0] Z_MAX   = SUM_W'(1048575);
  localparam logic signed [SUM_W-1:0] Z_MIN   = -SUM_W'(1048576);

  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] mag;

  assign sum = req_i.op_a + req_i.op_b;

  always_comb begin
    rsp_o.sum = sum;
    if (sum > ACC_MAX) begin
      rsp_o.acc_sat = ACC_W'(ACC_MAX);
    end else if (sum < ACC_MIN) begin
      rsp_o.acc_sat = ACC_W'(ACC_MIN);
    end else begin
      rsp_o.acc_sat = ACC_W'(sum);
    end

    // Bound check on the exact sum, then clip to the output range
    mag = req_i.z[SUM_W-1] ? SUM_W'(-req_i.z) : SUM_W'(req_i.z);
    rsp_o.oob = (mag >= {1'b0, bound_i});
    if (req_i.z > Z_MAX) begin
      rsp_o.z_sat = VALUE_W'(Z_MAX);
    end else if (req_i.z < Z_MIN) begin
      rsp_o.z_sat = VALUE_W'(Z_MIN);
    end else begin
      rsp_o.z_sat = VALUE_W'(req_i.z);
    end
  end

endmodule

// ----- rtl/stpm_seq.sv -----
// ----------------------------------------------------------------------------
// stpm_seq: command sequencer and accumulator sweep control
// Walks secret and accumulator RAMs one entry per cycle, owns the output word.
// ----------------------------------------------------------------------------
module stpm_seq #(
  parameter int DEGREE       = 256,
  parameter int POLY_COUNT   = 5,
  parameter int SECRET_RANGE = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [stpm_pkg::CMD_W-1:0]             cmd_i,
  input  logic [stpm_pkg::POLY_W-1:0]            poly_index_i,
  input  logic [stpm_pkg::COEFF_W-1:0]           coeff_index_i,
  input  logic signed [stpm_pkg::VALUE_W-1:0]    value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [stpm_pkg::VALUE_W-1:0]    z_value_o,
  output logic                                   out_of_bound_o,
  output logic                                   rejected_o,
  output logic                                   sec_we_o,
  output logic [$clog2(DEGREE*POLY_COUNT)-1:0]   sec_waddr_o,
  output logic [stpm_pkg::SEC_W-1:0]             sec_wdata_o,
  output logic [$clog2(DEGREE*POLY_COUNT)-1:0]   sec_raddr_o,
  input  logic [stpm_pkg::SEC_W-1:0]             sec_rdata_i,
  output logic                                   acc_we_o,
  output logic [$clog2(DEGREE*POLY_COUNT)-1:0]   acc_waddr_o,
  output logic [stpm_pkg::ACC_W-1:0]             acc_wdata_o,
  output logic [$clog2(DEGREE*POLY_COUNT)-1:0]   acc_raddr_o,
  input  logic [stpm_pkg::ACC_W-1:0]             acc_rdata_i,
  output stpm_pkg::alu_req_t                     alu_req_o,
  input  stpm_pkg::alu_rsp_t                     alu_rsp_i
);
  import stpm_pkg::*;

  localparam int SLOTS  = DEGREE * POLY_COUNT;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DEG_W  = $clog2(DEGREE);
  localparam int CMP_W  = ((DEG_W > COEFF_W) ? DEG_W : COEFF_W) + 1;

  localparam logic signed [VALUE_W-1:0] SEC_MAX = VALUE_W'(SECRET_RANGE);
  localparam logic signed [VALUE_W-1:0] SEC_MIN = -VALUE_W'(SECRET_RANGE);
  localparam logic signed [VALUE_W-1:0] ONE_P   = VALUE_W'(1);
  localparam logic signed [VALUE_W-1:0] ONE_N   = -VALUE_W'(1);

  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_LOAD  = 9'b000000100,
    ST_CHAL  = 9'b000001000,
    ST_DRAIN = 9'b000010000,
    ST_MADDR = 9'b000100000,
    ST_MSUM  = 9'b001000000,
    ST_CLEAR = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // latched input word
  cmd_e                       cmd_q;
  logic [POLY_W-1:0]          poly_q;
  logic [COEFF_W-1:0]         coeff_q;
  logic signed [VALUE_W-1:0]  value_q;

  // sweep counters
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] base_q, base_d;
  logic [DEG_W-1:0]  t_q, t_d;
  logic [DEG_W-1:0]  pos_q, pos_d;
  logic              wrap_q, wrap_d;

  // read-modify-write stage
  logic              s1_valid_q;
  logic [SLOT_W-1:0] wr_addr_q;
  logic              flip_q;

  logic signed [SUM_W-1:0] z_q, z_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_z_q, out_z_d;
  logic                      out_oob_q, out_oob_d;
  logic                      reject_q, reject_d;

  logic              accept;
  logic              poly_ok, coeff_ok, range_ok, chal_ok, slot_free;
  logic [SLOT_W-1:0] row_addr, chal_addr;
  logic signed [SEC_W-1:0]   sec_rd;
  logic signed [ACC_W-1:0]   acc_rd;
  logic signed [VALUE_W-1:0] sec_clip;
  logic signed [SUM_W-1:0]   delta;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  assign poly_ok  = {1'b0, poly_q} < (POLY_W + 1)'(POLY_COUNT);
  assign coeff_ok = CMP_W'(coeff_q) < CMP_W'(DEGREE);
  assign range_ok = poly_ok && coeff_ok;
  assign chal_ok  = coeff_ok && ((value_q == ONE_P) || (value_q == ONE_N));

  assign row_addr  = SLOT_W'(SLOT_W'(poly_q) * SLOT_W'(DEGREE) + SLOT_W'(coeff_q));
  assign chal_addr = base_q + SLOT_W'(pos_q);

  assign sec_rd = sec_rdata_i;
  assign acc_rd = acc_rdata_i;

  // secret clip
  always_comb begin
    if (value_q > SEC_MAX) begin
      sec_clip = SEC_MAX;
    end else if (value_q < SEC_MIN) begin
      sec_clip = SEC_MIN;
    end else begin
      sec_clip = value_q;
    end
  end

  assign sec_we_o    = (state_q == ST_LOAD) && range_ok;
  assign sec_waddr_o = row_addr;
  assign sec_wdata_o = SEC_W'(sec_clip);
  assign sec_raddr_o = slot_q;

  assign acc_raddr_o = (state_q == ST_CHAL) ? chal_addr : row_addr;

  // clear sweep or the write-back of the accumulator update
  always_comb begin
    if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
      acc_we_o    = 1'b1;
      acc_waddr_o = slot_q;
      acc_wdata_o = '0;
    end else begin
      acc_we_o    = s1_valid_q;
      acc_waddr_o = wr_addr_q;
      acc_wdata_o = alu_rsp_i.acc_sat;
    end
  end

  // shared adder operands
  always_comb begin
    delta = flip_q ? -SUM_W'(sec_rd) : SUM_W'(sec_rd);
    if (state_q == ST_MSUM) begin
      alu_req_o.op_a = SUM_W'(value_q);
      alu_req_o.op_b = range_ok ? SUM_W'(acc_rd) : '0;
    end else begin
      alu_req_o.op_a = SUM_W'(acc_rd);
      alu_req_o.op_b = delta;
    end
    alu_req_o.z = z_q;
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    base_d      = base_q;
    t_d         = t_q;
    pos_d       = pos_q;
    wrap_d      = wrap_q;
    z_d         = z_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_z_d     = out_z_q;
    out_oob_d   = out_oob_q;
    reject_d    = reject_q;

    case (state_q)
      ST_INIT: begin
        slot_d = slot_q + 1'b1;
        if (slot_q == SLOT_W'(SLOTS - 1)) begin
          slot_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_LOAD:  state_d = ST_LOAD;
            CMD_CHAL:  state_d = ST_CHAL;
            CMD_MASK:  state_d = ST_MADDR;
            CMD_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_DONE;
          endcase
          slot_d = '0;
          base_d = '0;
          t_d    = '0;
          pos_d  = DEG_W'(coeff_index_i);
          wrap_d = 1'b0;
        end
      end
      ST_LOAD: begin
        state_d = ST_DONE;
      end
      ST_CHAL: begin
        if (!chal_ok) begin
          state_d = ST_DONE;
        end else begin
          slot_d = slot_q + 1'b1;
          if (t_q == DEG_W'(DEGREE - 1)) begin
            t_d    = '0;
            base_d = base_q + SLOT_W'(DEGREE);
            pos_d  = DEG_W'(coeff_q);
            wrap_d = 1'b0;
            if (slot_q == SLOT_W'(SLOTS - 1)) begin
              state_d = ST_DRAIN;
            end
          end else begin
            t_d = t_q + 1'b1;
            if (pos_q == DEG_W'(DEGREE - 1)) begin
              pos_d  = '0;
              wrap_d = 1'b1;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_MADDR: begin
        state_d = ST_MSUM;
      end
      ST_MSUM: begin
        z_d     = alu_rsp_i.sum;
        state_d = ST_DONE;
      end
      ST_CLEAR: begin
        slot_d = slot_q + 1'b1;
        if (slot_q == SLOT_W'(SLOTS - 1)) begin
          slot_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_z_d     = '0;
          out_oob_d   = 1'b0;
          if (cmd_q == CMD_MASK) begin
            out_z_d   = alu_rsp_i.z_sat;
            out_oob_d = alu_rsp_i.oob;
            reject_d  = reject_q || alu_rsp_i.oob;
          end else if (cmd_q == CMD_CLEAR) begin
            reject_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      slot_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      reject_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      s1_valid_q  <= (state_q == ST_CHAL) && chal_ok;
      out_valid_q <= out_valid_d;
      reject_q    <= reject_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      poly_q  <= poly_index_i;
      coeff_q <= coeff_index_i;
      value_q <= value_i;
    end
    base_q    <= base_d;
    t_q       <= t_d;
    pos_q     <= pos_d;
    wrap_q    <= wrap_d;
    wr_addr_q <= chal_addr;
    flip_q    <= (value_q == ONE_N) ^ wrap_q;
    z_q       <= z_d;
    out_z_q   <= out_z_d;
    out_oob_q <= out_oob_d;
  end

  assign out_valid_o    = out_valid_q;
  assign z_value_o      = out_z_q;
  assign out_of_bound_o = out_oob_q;
  assign rejected_o     = reject_q;

endmodule

// ----- rtl/sparse_ternary_poly_mult_bound_check.sv -----
// ----------------------------------------------------------------------------
// sparse_ternary_poly_mult_bound_check: z = y + c*s1 with norm rejection
// Sparse ternary challenge times small secret in Z[x]/(x^N+1), L polynomials.
// ----------------------------------------------------------------------------
// One word is taken at a time and exactly one result word comes back for it.
// Timing is set by the accumulator RAM, which does one read-modify-write per
// cycle through a single shared adder: a challenge word (cmd 1) of +1 or -1
// sweeps all POLY_COUNT*DEGREE accumulators before its result, as does a
// clear (cmd 3), while a secret load (cmd 0) or a mask word (cmd 2) touches
// one entry. After reset the accumulators are zeroed by a pass over all
// POLY_COUNT*DEGREE entries before in_ready_o rises; the bound register may
// be written meanwhile. in_ready_o is high whenever the sequencer is idle,
// even while a result word still waits at the output.
// ----------------------------------------------------------------------------
module sparse_ternary_poly_mult_bound_check #(
  parameter int DEGREE       = 256,
  parameter int POLY_COUNT   = 5,
  parameter int SECRET_RANGE = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // bound register
  input  logic                                cfg_we_i,
  input  logic [stpm_pkg::BOUND_W-1:0]        cfg_wdata_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [stpm_pkg::CMD_W-1:0]          cmd_i,
  input  logic [stpm_pkg::POLY_W-1:0]         poly_index_i,
  input  logic [stpm_pkg::COEFF_W-1:0]        coeff_index_i,
  input  logic signed [stpm_pkg::VALUE_W-1:0] value_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [stpm_pkg::VALUE_W-1:0] z_value_o,
  output logic                                out_of_bound_o,
  output logic                                rejected_o
);
  import stpm_pkg::*;

  localparam int SLOTS  = DEGREE * POLY_COUNT;
  localparam int SLOT_W = $clog2(SLOTS);

  // Norm bound, reject when |z| >= bound
  logic [BOUND_W-1:0] bound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= BOUND_RESET;
    end else if (cfg_we_i) begin
      bound_q <= cfg_wdata_i;
    end
  end

  logic              sec_we;
  logic [SLOT_W-1:0] sec_waddr, sec_raddr;
  logic [SEC_W-1:0]  sec_wdata, sec_rdata;
  logic              acc_we;
  logic [SLOT_W-1:0] acc_waddr, acc_raddr;
  logic [ACC_W-1:0]  acc_wdata, acc_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // Sequencer: decodes commands, sweeps the stores, holds the result word
  stpm_seq #(
    .DEGREE       (DEGREE),
    .POLY_COUNT   (POLY_COUNT),
    .SECRET_RANGE (SECRET_RANGE)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .poly_index_i   (poly_index_i),
    .coeff_index_i  (coeff_index_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .z_value_o      (z_value_o),
    .out_of_bound_o (out_of_bound_o),
    .rejected_o     (rejected_o),
    .sec_we_o       (sec_we),
    .sec_waddr_o    (sec_waddr),
    .sec_wdata_o    (sec_wdata),
    .sec_raddr_o    (sec_raddr),
    .sec_rdata_i    (sec_rdata),
    .acc_we_o       (acc_we),
    .acc_waddr_o    (acc_waddr),
    .acc_wdata_o    (acc_wdata),
    .acc_raddr_o    (acc_raddr),
    .acc_rdata_i    (acc_rdata),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp)
  );

  // Secret coefficients, clipped on load; contents undefined until written
  stpm_ram #(
    .WIDTH (SEC_W),
    .DEPTH (SLOTS)
  ) u_secret_ram (
    .clk_i   (clk_i),
    .we_i    (sec_we),
    .waddr_i (sec_waddr),
    .wdata_i (sec_wdata),
    .raddr_i (sec_raddr),
    .rdata_o (sec_rdata)
  );

  // Product accumulators, saturating 12-bit
  stpm_ram #(
    .WIDTH (ACC_W),
    .DEPTH (SLOTS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // Shared adder plus the bound compare on the registered sum
  stpm_alu u_alu (
    .req_i   (alu_req),
    .bound_i (bound_q),
    .rsp_o   (alu_rsp)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sparse_ternary_poly_mult_bound_check
// Drives load, challenge, mask and clear words with random pacing, predicts
// every result word in a scoreboard class and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import stpm_pkg::*;

  // Block geometry, kept equal to the instance parameters below
  localparam int DEGREE       = 256;
  localparam int POLY_COUNT   = 5;
  localparam int SECRET_RANGE = 4;
  localparam int SLOT_COUNT   = POLY_COUNT * DEGREE;

  // Saturation limits of the accumulators and of the z output
  localparam int ACC_MAX = 2047;
  localparam int ACC_MIN = -2048;
  localparam int Z_MAX   = 1048575;
  localparam int Z_MIN   = -1048576;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 6;
  // The watchdog outlasts a challenge or clear sweeping every accumulator,
  // the long receiver hold, and the reset clearing pass.
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int LONG_HOLD_CYCLES = 2000;
  localparam int TAIL_CYCLES      = 1400;
  // 512 challenges of +/-4 per slot reach the 12-bit rails
  localparam int SAT_CHALLENGES   = 515;
  localparam int RAND_PHASES      = 6;
  localparam int RAND_PER_PHASE   = 60;

  typedef struct {
    logic signed [VALUE_W-1:0] z;
    logic                      oob;
    logic                      rej;
  } z_word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of secret, accumulators, sticky flag and bound.
  // note_word() runs on each accepted input word and queues the z word it
  // must produce; check_word() pops the oldest one for each result word.
  // --------------------------------------------------------------------------
  class zsum_scoreboard;
    logic signed [SEC_W-1:0] secret_mem [SLOT_COUNT];
    logic signed [ACC_W-1:0] acc_mem [SLOT_COUNT];
    logic                    reject_sticky;
    logic [BOUND_W-1:0]      bound;
    z_word_t                 z_expected_q [$];
    int                      errors;

    function new();
      foreach (secret_mem[i]) secret_mem[i] = '0;
      foreach (acc_mem[i]) acc_mem[i] = '0;
      reject_sticky = 1'b0;
      bound         = BOUND_RESET;
      errors        = 0;
    endfunction

    function void set_bound(logic [BOUND_W-1:0] b);
      bound = b;
    endfunction

    function int pending();
      return z_expected_q.size();
    endfunction

    function void note_word(cmd_e cmd, logic [POLY_W-1:0] p, logic [COEFF_W-1:0] k,
                            logic signed [VALUE_W-1:0] v);
      int      s, d, pos, slot;
      longint  sum, mag;
      z_word_t w;
      w.z   = '0;
      w.oob = 1'b0;
      case (cmd)
        CMD_LOAD: begin
          // out-of-range polynomial is dropped, value clamps to the secret range
          if (p < POLY_COUNT && k < DEGREE) begin
            s = v;
            if (s > SECRET_RANGE) s = SECRET_RANGE;
            if (s < -SECRET_RANGE) s = -SECRET_RANGE;
            secret_mem[p * DEGREE + k] = s[SEC_W-1:0];
          end
        end
        CMD_CHAL: begin
          // only +1 / -1 act; x^k * s1 with negation past x^N (negacyclic)
          if (k < DEGREE && (v == 1 || v == -1)) begin
            for (int q = 0; q < POLY_COUNT; q++) begin
              for (int t = 0; t < DEGREE; t++) begin
                d   = secret_mem[q * DEGREE + t];
                pos = k + t;
                if (v < 0) d = -d;
                if (pos >= DEGREE) begin
                  pos = pos - DEGREE;
                  d   = -d;
                end
                slot = q * DEGREE + pos;
                s    = acc_mem[slot] + d;
                if (s > ACC_MAX) s = ACC_MAX;
                if (s < ACC_MIN) s = ACC_MIN;
                acc_mem[slot] = s[ACC_W-1:0];
              end
            end
          end
        end
        CMD_MASK: begin
          sum = v;
          if (p < POLY_COUNT && k < DEGREE) sum = sum + acc_mem[p * DEGREE + k];
          // bound is checked on the exact sum, before z is clamped to 21 bits
          mag = (sum < 0) ? -sum : sum;
          if (mag >= longint'(bound)) begin
            w.oob         = 1'b1;
            reject_sticky = 1'b1;
          end
          if (sum > Z_MAX) sum = Z_MAX;
          if (sum < Z_MIN) sum = Z_MIN;
          w.z = sum[VALUE_W-1:0];
        end
        default: begin
          foreach (acc_mem[i]) acc_mem[i] = '0;
          reject_sticky = 1'b0;
        end
      endcase
      w.rej = reject_sticky;
      z_expected_q.push_back(w);
    endfunction

    function void check_word(logic signed [VALUE_W-1:0] z, logic oob, logic rej);
      z_word_t w;
      if (z_expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none outstanding: z=%0d oob=%0b rej=%0b",
                 $time, z, oob, rej);
        return;
      end
      w = z_expected_q.pop_front();
      if (z !== w.z) begin
        errors++;
        $display("%0t: z_value mismatch: expected %0d actual %0d", $time, w.z, z);
      end
      if (oob !== w.oob) begin
        errors++;
        $display("%0t: out_of_bound mismatch: expected %0b actual %0b", $time, w.oob, oob);
      end
      if (rej !== w.rej) begin
        errors++;
        $display("%0t: rejected mismatch: expected %0b actual %0b", $time, w.rej, rej);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [BOUND_W-1:0]        cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [CMD_W-1:0]          cmd_i;
  logic [POLY_W-1:0]         poly_index_i;
  logic [COEFF_W-1:0]        coeff_index_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [VALUE_W-1:0] z_value_o;
  logic                      out_of_bound_o;
  logic                      rejected_o;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sparse_ternary_poly_mult_bound_check #(
    .DEGREE       (DEGREE),
    .POLY_COUNT   (POLY_COUNT),
    .SECRET_RANGE (SECRET_RANGE)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .poly_index_i   (poly_index_i),
    .coeff_index_i  (coeff_index_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .z_value_o      (z_value_o),
    .out_of_bound_o (out_of_bound_o),
    .rejected_o     (rejected_o)
  );

  zsum_scoreboard sb;

  // sender pacing state
  int   burst_left;
  bit   gaps_on;
  // set by the stimulus, cleared by the receiver once the long hold begins
  bit   long_hold_pending;
  int   quiet_cycles;

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge; inputs only move on
  // the falling edge, so nothing here races the drivers. Also the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_word(cmd_e'(cmd_i), poly_index_i, coeff_index_i, value_i);
      if (out_valid_o && out_ready_i)
        sb.check_word(z_value_o, out_of_bound_o, rejected_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
        $display("FAIL sparse_ternary_poly_mult_bound_check");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns after spans of random length,
  // and does one long hold on request so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : rx_side
    rx_mode_e mode;
    int       span;
    int       tick;
    int       hold_left;
    mode        = RX_OPEN;
    span        = 0;
    tick        = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left         = LONG_HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          span = $urandom_range(32, 256);
        end
        span--;
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one word and hold it until accepted. valid is left high on return
  // so back-to-back words inside a burst see no bubble.
  task automatic send_word(input cmd_e c, input logic [POLY_W-1:0] p,
                           input logic [COEFF_W-1:0] k, input logic [VALUE_W-1:0] v);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    poly_index_i  <= p;
    coeff_index_i <= k;
    value_i       <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender pauses until every outstanding result word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Bound register write; only called with nothing in flight
  task automatic write_bound(input logic [BOUND_W-1:0] b);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_bound(b);
  endtask

  // y for a mask word: small, hugging the current bound, anything, or a corner value (a rail, 0 or -1)
  function automatic logic [VALUE_W-1:0] pick_mask_y();
    int b;
    b = sb.bound;
    case ($urandom_range(0, 3))
      0: return VALUE_W'($urandom_range(0, 6000) - 3000);
      1: return VALUE_W'(($urandom_range(0, 1) ? b : -b) + $urandom_range(0, 40) - 20);
      2: return VALUE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 21'h0FFFFF;
          1:       return 21'h100000;
          2:       return 21'h000000;
          default: return 21'h1FFFFF;
        endcase
      end
    endcase
  endfunction

  // Random word: ~30% loads, 15% challenges, 50% masks, 5% clears.
  // Polynomial index strays past POLY_COUNT now and then.
  task automatic send_random_word();
    int                  pick;
    cmd_e                c;
    logic [POLY_W-1:0]   p;
    logic [COEFF_W-1:0]  k;
    logic [VALUE_W-1:0]  v;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 8) p = POLY_W'($urandom_range(0, POLY_COUNT - 1));
    else p = POLY_W'($urandom_range(POLY_COUNT, 7));
    k = COEFF_W'($urandom);
    v = VALUE_W'($urandom);
    if (pick < 30) begin
      c = CMD_LOAD;
      if ($urandom_range(0, 9) < 8) v = VALUE_W'($urandom_range(0, 16) - 8);
    end else if (pick < 45) begin
      c = CMD_CHAL;
      case ($urandom_range(0, 9))
        8:       v = '0;
        9:       ;  // keep the random value, almost always a no-op
        default: v = $urandom_range(0, 1) ? 21'h000001 : 21'h1FFFFF;
      endcase
    end else if (pick < 95) begin
      c = CMD_MASK;
      v = pick_mask_y();
    end else begin
      c = CMD_CLEAR;
    end
    send_word(c, p, k, v);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [VALUE_W-1:0] v;
    logic [BOUND_W-1:0] b;
    sb                = new();
    burst_left        = 0;
    gaps_on           = 1'b1;
    long_hold_pending = 1'b0;
    quiet_cycles      = 0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    cmd_i             = CMD_LOAD;
    poly_index_i      = '0;
    coeff_index_i     = '0;
    value_i           = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Before any secret is complete only loads, masks and clears may go in.
    // Accumulators are zero, so masks see y alone against the reset bound.
    send_word(CMD_MASK, 3'd0, 8'd0, 21'h0FFFFF);    // top rail, flags and sets reject
    send_word(CMD_MASK, 3'd7, 8'd255, 21'h100000);  // bad poly, bottom rail
    send_word(CMD_CLEAR, 3'd2, 8'd77, 21'h0ABCDE);  // reject drops
    send_word(CMD_MASK, 3'd4, 8'd128, 21'd524091);  // just under bound
    send_word(CMD_MASK, 3'd1, 8'd3, -21'sd524092);  // exactly at bound, negative
    send_word(CMD_LOAD, 3'd5, 8'd0, 21'd3);         // bad poly, dropped
    send_word(CMD_LOAD, 3'd7, 8'd255, 21'h100000);  // bad poly, dropped
    send_word(CMD_CLEAR, 3'd0, 8'd0, 21'h000000);

    // Fill the whole secret so later challenges never touch unwritten entries.
    // One in eight values is far out of range and must clamp.
    for (int p = 0; p < POLY_COUNT; p++) begin
      for (int k = 0; k < DEGREE; k++) begin
        if (p == 0 && k == 0) v = 21'h0FFFFF;
        else if (p == 0 && k == 1) v = 21'h100000;
        else if ($urandom_range(0, 7) == 0) v = VALUE_W'($urandom);
        else v = VALUE_W'($urandom_range(0, 2 * SECRET_RANGE) - SECRET_RANGE);
        send_word(CMD_LOAD, POLY_W'(p), COEFF_W'(k), v);
      end
    end

    // Challenge corner cases: no wrap, full wrap, and values that do nothing
    send_word(CMD_CHAL, 3'd0, 8'd0, 21'h000001);
    send_word(CMD_CHAL, 3'd6, 8'd255, 21'h1FFFFF);  // -1 at the last index
    send_word(CMD_CHAL, 3'd1, 8'd7, 21'h000000);
    send_word(CMD_CHAL, 3'd2, 8'd9, 21'h000002);
    send_word(CMD_CHAL, 3'd3, 8'd1, 21'h100000);
    send_word(CMD_CHAL, 3'd4, 8'd200, 21'h0FFFFF);
    send_word(CMD_MASK, 3'd0, 8'd0, 21'h000000);
    send_word(CMD_MASK, 3'd4, 8'd255, 21'h000000);
    send_word(CMD_MASK, 3'd2, 8'd100, -21'sd7);
    // A late load leaves existing products alone
    send_word(CMD_LOAD, 3'd3, 8'd10, 21'd7);
    send_word(CMD_MASK, 3'd3, 8'd10, 21'h000000);
    send_word(CMD_CHAL, 3'd0, 8'd128, 21'h000001);
    send_word(CMD_MASK, 3'd3, 8'd10, 21'h000000);
    send_word(CMD_MASK, 3'd5, 8'd10, 21'd5);
    send_word(CMD_CLEAR, 3'd7, 8'd255, 21'h1FFFFF);
    send_word(CMD_MASK, 3'd0, 8'd0, 21'h000000);

    // Accumulator rails: hundreds of +1 challenges at index 0 pin every slot
    // whose secret is +4 at the top and every -4 slot at the bottom; slots 0
    // and 1 of polynomial 0 hold the clamped +4 and -4.
    send_word(CMD_CLEAR, 3'd0, 8'd0, 21'h000000);
    for (int n = 0; n < SAT_CHALLENGES; n++)
      send_word(CMD_CHAL, POLY_W'($urandom), 8'd0, 21'h000001);

    // z clamps at both rails; with the largest bound nothing flags,
    // with 2^20 the clamped words all flag since the check uses the exact sum.
    for (int r = 0; r < 2; r++) begin
      wait_drained();
      write_bound((r == 0) ? 21'h1FFFFF : 21'h100000);
      send_word(CMD_MASK, 3'd0, 8'd0, 21'h0FFFFF);
      send_word(CMD_MASK, 3'd0, 8'd1, 21'h100000);
      send_word(CMD_MASK, 3'd4, 8'd254, 21'h000000);
      send_word(CMD_MASK, 3'd4, 8'd255, 21'd5);
    end
    send_word(CMD_CLEAR, 3'd0, 8'd0, 21'h000000);

    // Random phases, one bound setting each; phase 2 runs without gaps and
    // phase 0 carries the long receiver hold.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       b = BOUND_RESET;
        1:       b = '0;
        2:       b = 21'h1FFFFF;
        3:       b = 21'h100000;
        4:       b = BOUND_W'($urandom_range(0, 4000));
        default: b = BOUND_W'($urandom);
      endcase
      write_bound(b);
      gaps_on = (ph != 2);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 0 && n == 30) long_hold_pending = 1'b1;
        send_random_word();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS sparse_ternary_poly_mult_bound_check");
    end else begin
      $display("FAIL sparse_ternary_poly_mult_bound_check");
    end
    $finish;
  end

endmodule
